@@ hdl/mlfq_pkg.sv @@
package mlfq_pkg;

  localparam int NUM_PROCS   = 16;
  localparam int QUEUE_DEPTH = 16;
  localparam int NUM_LEVELS  = 3;

  localparam int PID_W     = 4;
  localparam int BURST_W   = 16;
  localparam int QUANT_W   = 16;
  localparam int LEVEL_W   = 2;
  localparam int CFG_IDX_W = 1;
  localparam int QIDX_W    = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_ARRIVE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL0_QUANTUM = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL1_QUANTUM = 1'b1;

  localparam logic [LEVEL_W-1:0] LEVEL0 = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL1 = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL2 = 2'd2;

  typedef struct packed {
    logic             push;
    logic             pop;
    logic [PID_W-1:0] push_id;
  } fifo_ctl_t;

  typedef struct packed {
    logic [PID_W-1:0] head_id;
    logic             nonempty;
    logic             full;
  } fifo_stat_t;

  typedef struct packed {
    logic               en;
    logic [PID_W-1:0]   pid;
    logic [BURST_W-1:0] burst;
    logic [QUANT_W-1:0] quantum;
  } proc_wr_t;

  typedef struct packed {
    logic               ran;
    logic [PID_W-1:0]   run_process;
    logic [LEVEL_W-1:0] run_level;
    logic               finished;
    logic               demoted;
    logic               accepted;
  } result_t;

  function automatic logic [QIDX_W-1:0] next_slot(input logic [QIDX_W-1:0] idx);
    logic [QIDX_W-1:0] res;
    if (idx == QIDX_W'(QUEUE_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + QIDX_W'(1);
    end
    return res;
  endfunction

endpackage

@@ hdl/mlfq_level_fifo.sv @@
module mlfq_level_fifo
  import mlfq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  fifo_ctl_t  ctl,
  output fifo_stat_t stat
);

  logic [PID_W-1:0]  slots [QUEUE_DEPTH];
  logic [QIDX_W-1:0] head;
  logic [QIDX_W-1:0] head_next;
  logic [QIDX_W-1:0] tail;
  logic [QIDX_W-1:0] tail_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;

  assign head_next  = ctl.pop  ? next_slot(head) : head;
  assign tail_next  = ctl.push ? next_slot(tail) : tail;
  assign count_next = count + CNT_W'(ctl.push) - CNT_W'(ctl.pop);

  assign stat.head_id  = slots[head];
  assign stat.nonempty = (count != '0);
  assign stat.full     = (count == CNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // A pop and a push in the same cycle on a full queue write the slot being freed.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      slots[tail] <= ctl.push_id;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> count != '0)
    else $error("pop from an empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (ctl.push && !ctl.pop) |-> count != CNT_W'(QUEUE_DEPTH))
    else $error("push into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

@@ hdl/mlfq_proc_table.sv @@
module mlfq_proc_table
  import mlfq_pkg::*;
(
  input  logic               clk,
  input  logic [PID_W-1:0]   rd_pid,
  output logic [BURST_W-1:0] rd_burst,
  output logic [QUANT_W-1:0] rd_quantum,
  input  proc_wr_t           wr
);

  logic [BURST_W-1:0] burst_left   [NUM_PROCS];
  logic [QUANT_W-1:0] quantum_left [NUM_PROCS];

  assign rd_burst   = burst_left[rd_pid];
  assign rd_quantum = quantum_left[rd_pid];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      burst_left[wr.pid]   <= wr.burst;
      quantum_left[wr.pid] <= wr.quantum;
    end
  end

endmodule

@@ hdl/mlfq_three_level_scheduler_unit.sv @@
// Three-level feedback queue scheduler. Each input word is either a time tick or a process
// arrival and produces exactly one result word. The block takes one word per clock cycle
// unless a result waits to be taken: an accepted word sits in an input register, and in the
// cycle it moves to the result register the queue heads and the served process's burst and
// quantum counters are read, updated and written back, so the throughput is set by that
// single read-modify-write pass. A new word is accepted whenever the input register is
// empty or its word moves to the result register in that cycle, so a result that waits to
// be taken holds back at most one further word.
// There is no initialization sweep after reset; the block is ready once rst falls.
// The two quantum registers should be written only while no word is in flight.
module mlfq_three_level_scheduler_unit
  import mlfq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [QUANT_W-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 command,
  input  logic [PID_W-1:0]     process_id,
  input  logic [BURST_W-1:0]   burst_length,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 ran,
  output logic [PID_W-1:0]     run_process,
  output logic [LEVEL_W-1:0]   run_level,
  output logic                 finished,
  output logic                 demoted,
  output logic                 accepted
);

  logic [QUANT_W-1:0] level0_quantum;
  logic [QUANT_W-1:0] level1_quantum;

  logic               item_full;
  logic               item_command;
  logic [PID_W-1:0]   item_pid;
  logic [BURST_W-1:0] item_burst;

  logic fire;

  fifo_ctl_t  ctl  [NUM_LEVELS];
  fifo_stat_t stat [NUM_LEVELS];

  logic               sel_any;
  logic [LEVEL_W-1:0] sel_level;
  logic [PID_W-1:0]   head_pid;
  logic               lower_full;
  logic [BURST_W-1:0] rd_burst;
  logic [QUANT_W-1:0] rd_quantum;
  logic               run_now;
  logic [BURST_W-1:0] burst_after;
  logic [QUANT_W-1:0] quantum_after;
  proc_wr_t           tw;
  result_t            res;

  assign fire     = item_full && (!out_valid || out_ready);
  assign in_ready = !item_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      level0_quantum <= QUANT_W'(4);
      level1_quantum <= QUANT_W'(8);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_LEVEL0_QUANTUM: level0_quantum <= cfg_data;
        CFG_LEVEL1_QUANTUM: level1_quantum <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (in_ready) begin
      item_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_command <= command;
      item_pid     <= process_id;
      item_burst   <= burst_length;
    end
  end

  for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_level
    mlfq_level_fifo u_fifo (
      .clk  (clk),
      .rst  (rst),
      .ctl  (ctl[g]),
      .stat (stat[g])
    );
  end

  // The highest non-empty level is served.
  always_comb begin
    sel_any    = 1'b1;
    sel_level  = LEVEL0;
    head_pid   = stat[0].head_id;
    lower_full = stat[1].full;
    priority if (stat[0].nonempty) begin
      sel_level  = LEVEL0;
      head_pid   = stat[0].head_id;
      lower_full = stat[1].full;
    end else if (stat[1].nonempty) begin
      sel_level  = LEVEL1;
      head_pid   = stat[1].head_id;
      lower_full = stat[2].full;
    end else if (stat[2].nonempty) begin
      sel_level  = LEVEL2;
      head_pid   = stat[2].head_id;
      lower_full = 1'b1;
    end else begin
      sel_any = 1'b0;
    end
  end

  mlfq_proc_table u_table (
    .clk        (clk),
    .rd_pid     (head_pid),
    .rd_burst   (rd_burst),
    .rd_quantum (rd_quantum),
    .wr         (tw)
  );

  // Levels 0 and 1 run only while quantum is left; level 2 always runs.
  assign run_now       = (rd_quantum != '0) || (sel_level == LEVEL2);
  assign burst_after   = run_now ? rd_burst - BURST_W'(1) : rd_burst;
  assign quantum_after = (run_now && sel_level != LEVEL2) ? rd_quantum - QUANT_W'(1)
                                                          : rd_quantum;

  always_comb begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      ctl[i].push    = 1'b0;
      ctl[i].pop     = 1'b0;
      ctl[i].push_id = head_pid;
    end
    res        = '0;
    tw.en      = 1'b0;
    tw.pid     = head_pid;
    tw.burst   = burst_after;
    tw.quantum = quantum_after;

    if (item_command == CMD_ARRIVE) begin
      if (item_burst != '0 && 32'(item_pid) < NUM_PROCS && !stat[0].full) begin
        ctl[0].push    = 1'b1;
        ctl[0].push_id = item_pid;
        tw.en          = 1'b1;
        tw.pid         = item_pid;
        tw.burst       = item_burst;
        tw.quantum     = level0_quantum;
        res.accepted   = 1'b1;
      end
    end else if (sel_any) begin
      res.run_process = head_pid;
      res.run_level   = sel_level;
      if (rd_burst == '0) begin
        // Stale entry left behind by a repeated id: it leaves without running.
        ctl[sel_level].pop = 1'b1;
        res.finished       = 1'b1;
      end else begin
        res.ran = run_now;
        tw.en   = 1'b1;
        if (burst_after == '0) begin
          ctl[sel_level].pop = 1'b1;
          res.finished       = 1'b1;
        end else if (sel_level != LEVEL2 && quantum_after == '0) begin
          ctl[sel_level].pop = 1'b1;
          if (!lower_full) begin
            ctl[sel_level + LEVEL_W'(1)].push = 1'b1;
            tw.quantum  = (sel_level == LEVEL0) ? level1_quantum : '0;
            res.demoted = 1'b1;
          end else begin
            // The lower level is full, so the head rejoins its own tail.
            ctl[sel_level].push = 1'b1;
            tw.quantum = (sel_level == LEVEL0) ? level0_quantum : level1_quantum;
          end
        end
      end
    end

    if (!fire) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        ctl[i].push = 1'b0;
        ctl[i].pop  = 1'b0;
      end
      tw.en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      ran         <= res.ran;
      run_process <= res.run_process;
      run_level   <= res.run_level;
      finished    <= res.finished;
      demoted     <= res.demoted;
      accepted    <= res.accepted;
    end
  end

  a_fire_gives_word: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("processed word did not reach the result register");

  a_fin_dem_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(finished && demoted))
    else $error("a process both finished and was demoted");

  a_arrival_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && accepted) |-> (!ran && !finished && !demoted))
    else $error("arrival result carries run fields");

  a_demote_level: assert property (@(posedge clk) disable iff (rst)
    (out_valid && demoted) |-> (run_level == LEVEL0 || run_level == LEVEL1))
    else $error("demotion from the lowest level");

endmodule
